### rtl/core/eas_pkg.sv
package eas_pkg;

   // Default fraction bits of the ramp step.
   localparam int RAMP_FRAC_BITS_DEF = 15;

   // Field widths.
   localparam int CUR_W    = 15;
   localparam int TIME_W   = 16;
   localparam int ANGLE_W  = 16;
   localparam int SETTLE_W = 10;
   localparam int TICK_W   = 32;

   // Configuration port.
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_CUR = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALIGN_TIME = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIN_TIME  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SETTLE     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_SAVE_EN    = 3'd5;

   // Register reset values.
   localparam logic [CUR_W-1:0]    TARGET_CUR_RST = 15'd1000;
   localparam logic [TIME_W-1:0]   ALIGN_TIME_RST = 16'd1000;
   localparam logic [TIME_W-1:0]   SPIN_TIME_RST  = 16'd2000;
   localparam logic [CUR_W-1:0]    THRESHOLD_RST  = 15'd1000;
   localparam logic [SETTLE_W-1:0] SETTLE_RST     = 10'd100;

   typedef enum logic [2:0] {
      CMD_NONE   = 3'd0,
      CMD_SETREF = 3'd1,
      CMD_ALIGN  = 3'd2,
      CMD_SPIN   = 3'd3,
      CMD_STOP   = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_ALIGN  = 3'd1,
      PH_SETTLE = 3'd2,
      PH_SPIN   = 3'd3,
      PH_DONE   = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      CTL_IDLE,
      CTL_EVAL,
      CTL_DIV,
      CTL_MUL,
      CTL_PUT
   } ctl_state_type;

   typedef struct packed {
      logic                      mode;
      logic [TICK_W-1:0]         now_ms;
      logic                      start_request;
      logic                      motor_running;
      logic signed [ANGLE_W-1:0] mech_angle;
   } req_type;

   typedef struct packed {
      logic [2:0]                command;
      logic [CUR_W-1:0]          d_current_ref;
      logic signed [ANGLE_W-1:0] zero_offset;
      logic                      direction_negative;
      logic                      task_finished;
      logic                      save_request;
      logic [2:0]                phase;
      logic                      start_consumed;
   } rsp_type;

endpackage

### rtl/core/encoder_alignment_sequencer_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  eas_pkg::req_type (poll item)
// rsp_      out        rsp_valid / rsp_stall  eas_pkg::rsp_type (one result per item)
// csr_      in         csr_wr_en              csr_index, csr_wdata (write only)
//
// A plain poll item passes the evaluate and load states before its result is registered.
// An accepted start adds a pass through the serial restoring divider.
// A ramp step while aligning adds a pass through the serial shift-add multiplier.
// One item is in work at a time; the next transfer is taken once the result is loaded,
// even while that result is still stalled. Synchronous reset clears all but payload registers.
module encoder_alignment_sequencer_unit #(
   parameter int RAMP_FRAC_BITS = eas_pkg::RAMP_FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  eas_pkg::req_type                     req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output eas_pkg::rsp_type                     rsp_data,
   input  logic                                 csr_wr_en,
   input  logic [eas_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [eas_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   import eas_pkg::*;

   localparam int STEP_W = CUR_W + RAMP_FRAC_BITS;
   localparam int PROD_W = STEP_W + TIME_W;

   // Configuration registers.
   logic [CUR_W-1:0]    target_ff, target_in;
   logic [TIME_W-1:0]   align_time_ff, align_time_in;
   logic [TIME_W-1:0]   spin_time_ff, spin_time_in;
   logic [CUR_W-1:0]    thresh_ff, thresh_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;
   logic                save_en_ff, save_en_in;

   // Sequencer state.
   phase_type           phase_ff, phase_in;
   logic [STEP_W-1:0]   ramp_step_ff, ramp_step_in;
   logic [TICK_W-1:0]   time_mark_ff, time_mark_in;
   logic [ANGLE_W-1:0]  aligned_ff, aligned_in;
   logic [ANGLE_W-1:0]  offset_ff, offset_in;
   logic                dir_neg_ff, dir_neg_in;
   logic                done_flag_ff, done_flag_in;

   // Item in work and its pending result.
   req_type             item_ff, item_in;
   cmd_type             pend_cmd_ff, pend_cmd_in;
   logic [CUR_W-1:0]    pend_dref_ff, pend_dref_in;
   logic                pend_save_ff, pend_save_in;
   logic                pend_used_ff, pend_used_in;

   // Control and output register.
   ctl_state_type       ctl_state_ff, ctl_state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic                req_xfer;
   logic                out_free;
   logic [TICK_W-1:0]   elapsed;
   logic                align_over;
   logic                settle_over;
   logic                spin_live;
   logic [ANGLE_W-1:0]  delta;
   logic signed [ANGLE_W:0] delta_ext;
   logic signed [ANGLE_W:0] thresh_ext;
   logic                neg_hit;
   logic                pos_hit;
   logic                div_start;
   logic                div_done;
   logic [STEP_W-1:0]   div_quot;
   logic [TIME_W-1:0]   div_den;
   logic                mul_start;
   logic                mul_done;
   logic [PROD_W-1:0]   mul_prod;
   logic [CUR_W-1:0]    dref_sat;

   assign req_xfer  = req_valid && !req_stall;
   assign req_stall = ctl_state_ff != CTL_IDLE;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Time and angle compares on the item in work.
   always_comb begin
      elapsed     = item_ff.now_ms - time_mark_ff;
      align_over  = elapsed > {{(TICK_W-TIME_W){1'b0}}, align_time_ff};
      settle_over = elapsed >= {{(TICK_W-SETTLE_W){1'b0}}, settle_ff};
      spin_live   = elapsed < {{(TICK_W-TIME_W){1'b0}}, spin_time_ff};
      delta       = item_ff.mech_angle - aligned_ff;
      delta_ext   = $signed({delta[ANGLE_W-1], delta});
      thresh_ext  = $signed({2'b00, thresh_ff});
      neg_hit     = delta_ext < -thresh_ext;
      pos_hit     = delta_ext > thresh_ext;
   end

   // Zero ramp duration divides by one.
   assign div_den = (align_time_ff == '0) ? TIME_W'(1) : align_time_ff;

   eas_div #(
      .NUM_W(STEP_W),
      .DEN_W(TIME_W)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_start),
      .num  ({target_ff, {RAMP_FRAC_BITS{1'b0}}}),
      .den  (div_den),
      .done (div_done),
      .quot (div_quot)
   );

   eas_mul #(
      .MC_W(STEP_W),
      .MP_W(TIME_W)
   ) u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .mcand (ramp_step_ff),
      .mplier(elapsed[TIME_W-1:0]),
      .done  (mul_done),
      .prod  (mul_prod)
   );

   // Drop the fraction bits and saturate the current reference.
   always_comb begin
      if (|mul_prod[PROD_W-1:RAMP_FRAC_BITS+CUR_W]) begin
         dref_sat = '1;
      end else begin
         dref_sat = mul_prod[RAMP_FRAC_BITS+CUR_W-1:RAMP_FRAC_BITS];
      end
   end

   // Configuration writes.
   always_comb begin
      target_in     = target_ff;
      align_time_in = align_time_ff;
      spin_time_in  = spin_time_ff;
      thresh_in     = thresh_ff;
      settle_in     = settle_ff;
      save_en_in    = save_en_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_TARGET_CUR: target_in     = csr_wdata[CUR_W-1:0];
            CSR_ALIGN_TIME: align_time_in = csr_wdata[TIME_W-1:0];
            CSR_SPIN_TIME:  spin_time_in  = csr_wdata[TIME_W-1:0];
            CSR_THRESHOLD:  thresh_in     = csr_wdata[CUR_W-1:0];
            CSR_SETTLE:     settle_in     = csr_wdata[SETTLE_W-1:0];
            CSR_SAVE_EN:    save_en_in    = csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   // Next state of the control sequencer.
   always_comb begin
      ctl_state_in = ctl_state_ff;
      case (ctl_state_ff)
         CTL_IDLE: begin
            if (req_xfer) begin
               ctl_state_in = CTL_EVAL;
            end
         end
         CTL_EVAL: begin
            ctl_state_in = CTL_PUT;
            if (!item_ff.mode) begin
               if (phase_ff == PH_IDLE && item_ff.start_request) begin
                  ctl_state_in = CTL_DIV;
               end else if (phase_ff == PH_ALIGN && !align_over) begin
                  ctl_state_in = CTL_MUL;
               end
            end
         end
         CTL_DIV: begin
            if (div_done) begin
               ctl_state_in = CTL_PUT;
            end
         end
         CTL_MUL: begin
            if (mul_done) begin
               ctl_state_in = CTL_PUT;
            end
         end
         CTL_PUT: begin
            if (out_free) begin
               ctl_state_in = CTL_IDLE;
            end
         end
         default: ctl_state_in = CTL_IDLE;
      endcase
   end

   // Sequencer updates, unit launches and the result register.
   always_comb begin
      item_in      = req_xfer ? req_data : item_ff;
      phase_in     = phase_ff;
      ramp_step_in = ramp_step_ff;
      time_mark_in = time_mark_ff;
      aligned_in   = aligned_ff;
      offset_in    = offset_ff;
      dir_neg_in   = dir_neg_ff;
      done_flag_in = done_flag_ff;
      pend_cmd_in  = pend_cmd_ff;
      pend_dref_in = pend_dref_ff;
      pend_save_in = pend_save_ff;
      pend_used_in = pend_used_ff;
      div_start    = 1'b0;
      mul_start    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;

      case (ctl_state_ff)
         CTL_EVAL: begin
            pend_cmd_in  = CMD_NONE;
            pend_dref_in = '0;
            pend_save_in = 1'b0;
            pend_used_in = 1'b0;
            if (item_ff.mode) begin
               done_flag_in = 1'b0;
               phase_in     = PH_IDLE;
            end else begin
               case (phase_ff)
                  PH_IDLE: begin
                     if (item_ff.start_request) begin
                        offset_in    = '0;
                        dir_neg_in   = 1'b0;
                        pend_cmd_in  = CMD_ALIGN;
                        pend_used_in = 1'b1;
                        time_mark_in = item_ff.now_ms;
                        phase_in     = PH_ALIGN;
                        div_start    = 1'b1;
                     end
                  end
                  PH_ALIGN: begin
                     if (align_over) begin
                        if (item_ff.motor_running) begin
                           offset_in    = ANGLE_W'(0) - item_ff.mech_angle;
                           time_mark_in = item_ff.now_ms;
                           phase_in     = PH_SETTLE;
                        end else begin
                           pend_cmd_in = CMD_STOP;
                           phase_in    = PH_IDLE;
                        end
                     end else begin
                        pend_cmd_in = CMD_SETREF;
                        mul_start   = 1'b1;
                     end
                  end
                  PH_SETTLE: begin
                     if (settle_over) begin
                        aligned_in   = item_ff.mech_angle;
                        pend_cmd_in  = CMD_SPIN;
                        time_mark_in = item_ff.now_ms;
                        phase_in     = PH_SPIN;
                     end
                  end
                  PH_SPIN: begin
                     if (spin_live) begin
                        if (neg_hit || pos_hit) begin
                           dir_neg_in   = neg_hit;
                           pend_cmd_in  = CMD_STOP;
                           done_flag_in = 1'b1;
                           pend_save_in = save_en_ff;
                           phase_in     = PH_DONE;
                        end
                     end else begin
                        pend_cmd_in  = CMD_STOP;
                        done_flag_in = 1'b1;
                        phase_in     = PH_IDLE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         CTL_DIV: begin
            if (div_done) begin
               ramp_step_in = (div_quot == '0) ? STEP_W'(1) : div_quot;
            end
         end
         CTL_MUL: begin
            if (mul_done) begin
               pend_dref_in = dref_sat;
            end
         end
         CTL_PUT: begin
            if (out_free) begin
               rsp_valid_in                   = 1'b1;
               rsp_data_in.command            = pend_cmd_ff;
               rsp_data_in.d_current_ref      = pend_dref_ff;
               rsp_data_in.zero_offset        = offset_ff;
               rsp_data_in.direction_negative = dir_neg_ff;
               rsp_data_in.task_finished      = done_flag_ff;
               rsp_data_in.save_request       = pend_save_ff;
               rsp_data_in.phase              = phase_ff;
               rsp_data_in.start_consumed     = pend_used_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_state_ff  <= CTL_IDLE;
         rsp_valid_ff  <= 1'b0;
         target_ff     <= TARGET_CUR_RST;
         align_time_ff <= ALIGN_TIME_RST;
         spin_time_ff  <= SPIN_TIME_RST;
         thresh_ff     <= THRESHOLD_RST;
         settle_ff     <= SETTLE_RST;
         save_en_ff    <= 1'b0;
         phase_ff      <= PH_IDLE;
         ramp_step_ff  <= '0;
         time_mark_ff  <= '0;
         aligned_ff    <= '0;
         offset_ff     <= '0;
         dir_neg_ff    <= 1'b0;
         done_flag_ff  <= 1'b0;
      end else begin
         ctl_state_ff  <= ctl_state_in;
         rsp_valid_ff  <= rsp_valid_in;
         target_ff     <= target_in;
         align_time_ff <= align_time_in;
         spin_time_ff  <= spin_time_in;
         thresh_ff     <= thresh_in;
         settle_ff     <= settle_in;
         save_en_ff    <= save_en_in;
         phase_ff      <= phase_in;
         ramp_step_ff  <= ramp_step_in;
         time_mark_ff  <= time_mark_in;
         aligned_ff    <= aligned_in;
         offset_ff     <= offset_in;
         dir_neg_ff    <= dir_neg_in;
         done_flag_ff  <= done_flag_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      pend_cmd_ff  <= pend_cmd_in;
      pend_dref_ff <= pend_dref_in;
      pend_save_ff <= pend_save_in;
      pend_used_ff <= pend_used_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The divider only finishes while the sequencer waits for it.
   a_div_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      div_done |-> ctl_state_ff == CTL_DIV)
      else $error("divider finished outside its wait state");

   // The multiplier only finishes while the sequencer waits for it.
   a_mul_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> ctl_state_ff == CTL_MUL)
      else $error("multiplier finished outside its wait state");

   // A ramp product is only formed after a start has set a nonzero step.
   a_step_nonzero: assert property (@(posedge clock) disable iff (reset)
      ctl_state_ff == CTL_MUL |-> ramp_step_ff != '0)
      else $error("ramp step is zero during a ramp product");

   // A new result appears only out of the result load state.
   a_rsp_from_put: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl_state_ff == CTL_PUT))
      else $error("result raised outside the load state");

endmodule

### rtl/core/eas_div.sv
module eas_div #(
   parameter int NUM_W = 30,
   parameter int DEN_W = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic             done,
   output logic [NUM_W-1:0] quot
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   rem_sub;
   logic             fits;

   // One quotient bit per cycle: shift in the next dividend bit and try a subtract.
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[NUM_W-1]};
      fits    = rem_sh >= {1'b0, den_ff};
      rem_sub = rem_sh - {1'b0, den_ff};
   end

   // Next values of the shift registers and the step counter.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[NUM_W-2:0], fits};
         rem_in = fits ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = quo_ff;

endmodule

### rtl/core/eas_mul.sv
module eas_mul #(
   parameter int MC_W = 30,
   parameter int MP_W = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [MC_W-1:0]       mcand,
   input  logic [MP_W-1:0]       mplier,
   output logic                  done,
   output logic [MC_W+MP_W-1:0]  prod
);

   localparam int PW    = MC_W + MP_W;
   localparam int CNT_W = $clog2(MP_W + 1);

   logic [PW-1:0]    prod_ff, prod_in;
   logic [MC_W-1:0]  mcand_ff, mcand_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [MC_W:0]    part_sum;

   // Add the multiplicand when the current multiplier bit is set.
   always_comb begin
      part_sum = {1'b0, prod_ff[PW-1:MP_W]} + (prod_ff[0] ? {1'b0, mcand_ff} : '0);
   end

   // Shift-add step, one multiplier bit per cycle, least significant first.
   always_comb begin
      prod_in  = prod_ff;
      mcand_in = mcand_ff;
      cnt_in   = cnt_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         prod_in  = {{MC_W{1'b0}}, mplier};
         mcand_in = mcand;
         cnt_in   = CNT_W'(MP_W);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         prod_in = {part_sum, prod_ff[MP_W-1:1]};
         cnt_in  = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      prod_ff  <= prod_in;
      mcand_ff <= mcand_in;
   end

   assign done = done_ff;
   assign prod = prod_ff;

endmodule
